// ----- rtl/tcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg
// Types, constants and the arctangent table for the texcoord projection.
// ----------------------------------------------------------------------------
package tcp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int COORD_WIDTH   = 16;
	localparam int FRAC_BITS     = COORD_WIDTH - 3;
	localparam int GUARD         = 40 - COORD_WIDTH;
	localparam int CW            = 44;
	localparam int AW            = 36;
	localparam int IDX_W         = 5;
	localparam int TURN_SH       = 32 - FRAC_BITS;

	localparam logic [1:0] MODE_PLANAR   = 2'd0;
	localparam logic [1:0] MODE_CYLINDER = 2'd1;
	localparam logic [1:0] MODE_SPHERE   = 2'd2;

	localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);
	localparam logic signed [20:0]   INV_GAIN  = 21'sd636751;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vertex_x;
		logic signed [COORD_WIDTH-1:0] vertex_y;
		logic signed [COORD_WIDTH-1:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] tex_s;
		logic signed [COORD_WIDTH-1:0] tex_t;
	} texcoord_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
	} cordic_t;

	function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = AW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
		lo = -hi - AW'(1);
		if (v > hi)
			return hi[COORD_WIDTH-1:0];
		else if (v < lo)
			return lo[COORD_WIDTH-1:0];
		else
			return v[COORD_WIDTH-1:0];
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] planar(
		input logic signed [COORD_WIDTH-1:0] v);
		logic signed [AW-1:0] e;
		e = AW'(v) + AW'(64'sd1 <<< FRAC_BITS);
		return sat(e >>> 1);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] turns(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] e;
		e = a + HALF_TURN + AW'(64'sd1 <<< (TURN_SH - 1));
		return sat(e >>> TURN_SH);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tcp_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_cordic_cell
// One CORDIC vectoring micro-rotation, registered.
// ----------------------------------------------------------------------------
module tcp_cordic_cell (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [tcp_pkg::IDX_W-1:0] idx,
	input  wire tcp_pkg::cordic_t       d,
	output tcp_pkg::cordic_t            q
);
	import tcp_pkg::*;

	cordic_t              nxt;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [AW-1:0] at;

	always_comb begin
		dx = d.y >>> idx;
		dy = d.x >>> idx;
		at = $signed({{(AW-32){1'b0}}, atan_turn(idx)});
		if (!d.y[CW-1]) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.ang = d.ang + at;
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.ang = d.ang - at;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nxt;
	end

endmodule
`default_nettype wire

// ----- rtl/texcoord_projection.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// texcoord_projection
// Planar / cylinder / sphere texture coordinates from a vertex stream.
// ----------------------------------------------------------------------------
// Channel  Signals                       Dir  Moves
// in       in_valid/in_stall/in_data     in   vertex transaction
// out      out_valid/out_stall/out_data  out  texcoord transaction
// cfg      cfg_valid/cfg_ready/cfg_data  in   projection mode write
//
// One vertex per cycle, through two chains of CORDIC cells, each with a
// prep stage, plus a gain multiply stage and an output register.
// Reset clears valids and mode. The whole pipeline freezes while a result
// sits in the output register under out_stall.
// ----------------------------------------------------------------------------
module texcoord_projection (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tcp_pkg::vertex_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tcp_pkg::texcoord_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_data
);
	import tcp_pkg::*;

	localparam int N = CORDIC_STAGES;

	typedef struct packed {
		logic [1:0]                    mode;
		logic                          zero;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} side1_t;

	typedef struct packed {
		logic                          sph;
		logic                          zero;
		logic signed [COORD_WIDTH-1:0] s;
		logic signed [COORD_WIDTH-1:0] tp;
	} side2_t;

	logic       adv;
	logic [1:0] mode_q;

	cordic_t c1 [0:N];
	cordic_t c2 [0:N];
	side1_t  sd1_q [0:N];
	side2_t  sd2_q [0:N];
	logic    v1_q [0:N];
	logic    v2_q [0:N];

	logic                          vg_s1;
	side2_t                        sg_s1;
	logic signed [CW-1:0]          yg_s1;
	logic signed [CW+20:0]         prod_s1;

	logic                          vo_q;
	texcoord_t                     out_q;

	assign adv       = !(vo_q && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vo_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_PLANAR;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	// first chain prep: atan2(x, z)
	logic signed [CW-1:0] px1;
	logic signed [CW-1:0] py1;
	cordic_t              p1;
	always_comb begin
		px1 = CW'(in_data.vertex_z) <<< GUARD;
		py1 = CW'(in_data.vertex_x) <<< GUARD;
		p1  = '{x: px1, y: py1, ang: '0};
		if (px1[CW-1]) begin
			p1.x   = -px1;
			p1.y   = -py1;
			p1.ang = py1[CW-1] ? -HALF_TURN : HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1[0]  <= p1;
			sd1_q[0] <= '{mode: mode_q, zero: (px1 == '0) && (py1 == '0),
				x: in_data.vertex_x, y: in_data.vertex_y};
		end
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_chain
			tcp_cordic_cell u_c1 (.clk(clk), .en(adv), .idx(IDX_W'(g)),
				.d(c1[g]), .q(c1[g+1]));
			tcp_cordic_cell u_c2 (.clk(clk), .en(adv), .idx(IDX_W'(g)),
				.d(c2[g]), .q(c2[g+1]));
			always_ff @(posedge clk) begin
				if (adv) begin
					sd1_q[g+1] <= sd1_q[g];
					sd2_q[g+1] <= sd2_q[g];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v1_q[g+1] <= 1'b0;
					v2_q[g+1] <= 1'b0;
				end else if (adv) begin
					v1_q[g+1] <= v1_q[g];
					v2_q[g+1] <= v2_q[g];
				end
			end
		end
	endgenerate

	// gain stage: s, planar t, magnitude times inverse gain
	side1_t  e1;
	logic    cyl1;
	logic signed [COORD_WIDTH-1:0] s1;
	always_comb begin
		e1   = sd1_q[N];
		cyl1 = (e1.mode == MODE_CYLINDER) || (e1.mode == MODE_SPHERE);
		s1   = e1.zero ? turns('0) : turns(c1[N].ang);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= c1[N].x * INV_GAIN;
			yg_s1   <= CW'(e1.y) <<< GUARD;
			sg_s1   <= '{sph: e1.mode == MODE_SPHERE, zero: 1'b0,
				s: cyl1 ? s1 : planar(e1.x),
				tp: planar(e1.y)};
		end
	end

	// second chain prep: atan2(r, y)
	logic signed [CW-1:0] px2;
	logic signed [CW-1:0] py2;
	cordic_t              p2;
	side2_t               sp2;
	always_comb begin
		px2 = yg_s1;
		py2 = prod_s1[CW+19:20];
		p2  = '{x: px2, y: py2, ang: '0};
		if (px2[CW-1]) begin
			p2.x   = -px2;
			p2.y   = -py2;
			p2.ang = py2[CW-1] ? -HALF_TURN : HALF_TURN;
		end
		sp2      = sg_s1;
		sp2.zero = (px2 == '0) && (py2 == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c2[0]    <= p2;
			sd2_q[0] <= sp2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q[0] <= 1'b0;
			vg_s1   <= 1'b0;
			v2_q[0] <= 1'b0;
			vo_q    <= 1'b0;
		end else if (adv) begin
			v1_q[0] <= in_valid;
			vg_s1   <= v1_q[N];
			v2_q[0] <= vg_s1;
			vo_q    <= v2_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.tex_s <= sd2_q[N].s;
			if (sd2_q[N].sph)
				out_q.tex_t <= sd2_q[N].zero ? turns('0) : turns(c2[N].ang);
			else
				out_q.tex_t <= sd2_q[N].tp;
		end
	end

	ap_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");
	ap_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v2_q[N]) |=> out_valid)
		else $error("result lost at output register");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(vg_s1) && $stable(v1_q[0])))
		else $error("pipeline moved while frozen");

endmodule
`default_nettype wire
